### rtl/alist_pkg.sv
package alist_pkg;

   // Storage size and derived widths.
   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = 7;
   localparam int POS_W    = 7;
   localparam int VAL_W    = 32;
   localparam int IDX_W    = 7;

   localparam logic [CNT_W-1:0] LEN_CAP = CNT_W'(CAPACITY);

   // Request operation codes.
   typedef enum logic [1:0] {
      OP_INSERT     = 2'd0,
      OP_SEARCH     = 2'd1,
      OP_DELETE_POS = 2'd2,
      OP_DELETE_VAL = 2'd3
   } op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic start_ins;
      logic start_del;
      logic start_srch;
      logic start_delv;
      logic step_ins;
      logic step_del;
      logic step_srch;
      logic len_inc;
      logic len_dec;
      logic rsp_load;
      logic rsp_ok;
      logic rsp_hit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic ins_ok;
      logic del_ok;
      logic ins_more;
      logic del_more;
      logic hit;
      logic srch_end;
   } status_type;

endpackage

### rtl/alist_req_if.sv
interface alist_req_if import alist_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               operation;
   logic [POS_W-1:0]         position;
   logic signed [VAL_W-1:0]  value;

   modport source (output valid, operation, position, value, input ready);
   modport sink   (input valid, operation, position, value, output ready);
endinterface

### rtl/alist_rsp_if.sv
interface alist_rsp_if import alist_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     ok;
   logic signed [IDX_W-1:0]  found_index;
   logic [CNT_W-1:0]         count;

   modport source (output valid, ok, found_index, count, input ready);
   modport sink   (input valid, ok, found_index, count, output ready);
endinterface

### rtl/alist_dp.sv
module alist_dp import alist_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [POS_W-1:0]        req_position,
   input  logic signed [VAL_W-1:0] req_value,
   input  cmd_type                 cmd,
   output status_type              status,
   output logic                    rsp_ok,
   output logic signed [IDX_W-1:0] rsp_found_index,
   output logic [CNT_W-1:0]        rsp_count
);

   // Entry store with a registered read port.
   logic [VAL_W-1:0] entry_mem [CAPACITY];
   logic [VAL_W-1:0] rd_ff;
   logic [ADDR_W-1:0] rd_addr;

   // Request registers, list length and walking cursor.
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [VAL_W-1:0]  key_ff, key_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [CNT_W-1:0]  cur_ff, cur_in;

   // Write stage: a shifted word or the new value lands in the cycle after its read.
   logic              wpend_ff, wpend_in;
   logic [ADDR_W-1:0] waddr_ff, waddr_in;
   logic              wsel_ff, wsel_in;

   // Compare stage of the search walk.
   logic              cpend_ff, cpend_in;
   logic [ADDR_W-1:0] cidx_ff, cidx_in;
   logic [ADDR_W-1:0] hit_idx_ff, hit_idx_in;

   // Result word.
   logic              rsp_ok_ff, rsp_ok_in;
   logic [IDX_W-1:0]  rsp_fidx_ff, rsp_fidx_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic match;

   // Status toward the controller.
   assign match = cpend_ff && (rd_ff == key_ff);

   always_comb begin
      status.ins_ok   = (pos_ff <= len_ff) && (len_ff < LEN_CAP);
      status.del_ok   = (pos_ff < len_ff);
      status.ins_more = (cur_ff > pos_ff);
      status.del_more = ((cur_ff + CNT_W'(1)) < len_ff);
      status.hit      = match;
      status.srch_end = !cpend_ff && (cur_ff >= len_ff);
   end

   // Next values of the walk and the request registers.
   always_comb begin
      pos_in      = pos_ff;
      key_in      = key_ff;
      cur_in      = cur_ff;
      wpend_in    = 1'b0;
      waddr_in    = waddr_ff;
      wsel_in     = wsel_ff;
      cpend_in    = 1'b0;
      cidx_in     = cidx_ff;
      hit_idx_in  = hit_idx_ff;
      rd_addr     = cur_ff[ADDR_W-1:0];

      if (cmd.capture) begin
         pos_in = req_position;
         key_in = req_value;
      end

      if (match) begin
         hit_idx_in = cidx_ff;
      end

      if (cmd.step_ins) begin
         if (cur_ff > pos_ff) begin
            rd_addr  = ADDR_W'(cur_ff - CNT_W'(1));
            wpend_in = 1'b1;
            waddr_in = cur_ff[ADDR_W-1:0];
            wsel_in  = 1'b0;
            cur_in   = cur_ff - CNT_W'(1);
         end else begin
            wpend_in = 1'b1;
            waddr_in = pos_ff[ADDR_W-1:0];
            wsel_in  = 1'b1;
         end
      end

      if (cmd.step_del) begin
         rd_addr = ADDR_W'(cur_ff + CNT_W'(1));
         if ((cur_ff + CNT_W'(1)) < len_ff) begin
            wpend_in = 1'b1;
            waddr_in = cur_ff[ADDR_W-1:0];
            wsel_in  = 1'b0;
            cur_in   = cur_ff + CNT_W'(1);
         end
      end

      if (cmd.step_srch) begin
         if (cur_ff < len_ff) begin
            cpend_in = 1'b1;
            cidx_in  = cur_ff[ADDR_W-1:0];
            cur_in   = cur_ff + CNT_W'(1);
         end
      end

      // Starting points of each walk take priority over a step.
      if (cmd.start_ins) begin
         cur_in = len_ff;
      end
      if (cmd.start_del) begin
         cur_in = pos_ff;
      end
      if (cmd.start_srch) begin
         cur_in = '0;
      end
      if (cmd.start_delv) begin
         cur_in = {1'b0, cidx_ff};
      end
   end

   // Length update and result word.
   always_comb begin
      len_in       = len_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_fidx_in  = rsp_fidx_ff;
      rsp_count_in = rsp_count_ff;
      if (cmd.len_inc) begin
         len_in = len_ff + CNT_W'(1);
      end else if (cmd.len_dec) begin
         len_in = len_ff - CNT_W'(1);
      end
      if (cmd.rsp_load) begin
         rsp_ok_in    = cmd.rsp_ok;
         rsp_fidx_in  = cmd.rsp_hit ? IDX_W'(hit_idx_ff) : '1;
         rsp_count_in = len_in;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         wpend_ff <= 1'b0;
         cpend_ff <= 1'b0;
      end else begin
         len_ff   <= len_in;
         wpend_ff <= wpend_in;
         cpend_ff <= cpend_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      key_ff       <= key_in;
      cur_ff       <= cur_in;
      waddr_ff     <= waddr_in;
      wsel_ff      <= wsel_in;
      cidx_ff      <= cidx_in;
      hit_idx_ff   <= hit_idx_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_fidx_ff  <= rsp_fidx_in;
      rsp_count_ff <= rsp_count_in;
   end

   // Single write port and registered read port of the store.
   always_ff @(posedge clock) begin
      if (wpend_ff) begin
         entry_mem[waddr_ff] <= wsel_ff ? key_ff : rd_ff;
      end
      rd_ff <= entry_mem[rd_addr];
   end

   assign rsp_ok          = rsp_ok_ff;
   assign rsp_found_index = rsp_fidx_ff;
   assign rsp_count       = rsp_count_ff;

   // The list never grows past its capacity.
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_CAP)
      else $error("list length exceeds capacity");

   // Growing and shrinking the list are never asked for together.
   a_len_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.len_inc && cmd.len_dec))
      else $error("length increment and decrement together");

   // An insert adds exactly one entry.
   a_len_inc: assert property (@(posedge clock) disable iff (reset)
      cmd.len_inc |=> len_ff == $past(len_ff) + CNT_W'(1))
      else $error("length did not grow by one");

   // Shift writes stay inside the list plus the slot an insert opens.
   a_waddr: assert property (@(posedge clock) disable iff (reset)
      wpend_ff |-> ({1'b0, waddr_ff} <= len_ff))
      else $error("store write beyond the list");

endmodule

### rtl/alist_ctrl.sv
module alist_ctrl import alist_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_operation,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DECODE = 6'b000010,
      ST_INS    = 6'b000100,
      ST_DEL    = 6'b001000,
      ST_SRCH   = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic      res_ok_ff, res_ok_in;
   logic      res_hit_ff, res_hit_in;
   logic      res_inc_ff, res_inc_in;
   logic      res_dec_ff, res_dec_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Sequencer: decode, walk the store, then hand over the result word.
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      res_ok_in  = res_ok_ff;
      res_hit_in = res_hit_ff;
      res_inc_in = res_inc_ff;
      res_dec_in = res_dec_ff;
      cmd        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               op_in       = op_type'(req_operation);
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            res_ok_in  = 1'b0;
            res_hit_in = 1'b0;
            res_inc_in = 1'b0;
            res_dec_in = 1'b0;
            case (op_ff)
               OP_INSERT: begin
                  if (status.ins_ok) begin
                     cmd.start_ins = 1'b1;
                     res_ok_in     = 1'b1;
                     res_inc_in    = 1'b1;
                     state_in      = ST_INS;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
               OP_DELETE_POS: begin
                  if (status.del_ok) begin
                     cmd.start_del = 1'b1;
                     res_ok_in     = 1'b1;
                     res_dec_in    = 1'b1;
                     state_in      = ST_DEL;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
               default: begin
                  cmd.start_srch = 1'b1;
                  state_in       = ST_SRCH;
               end
            endcase
         end
         ST_INS: begin
            cmd.step_ins = 1'b1;
            if (!status.ins_more) begin
               state_in = ST_FINISH;
            end
         end
         ST_DEL: begin
            cmd.step_del = 1'b1;
            if (!status.del_more) begin
               state_in = ST_FINISH;
            end
         end
         ST_SRCH: begin
            if (status.hit) begin
               res_ok_in  = 1'b1;
               res_hit_in = 1'b1;
               if (op_ff == OP_DELETE_VAL) begin
                  cmd.start_delv = 1'b1;
                  res_dec_in     = 1'b1;
                  state_in       = ST_DEL;
               end else begin
                  state_in = ST_FINISH;
               end
            end else if (status.srch_end) begin
               state_in = ST_FINISH;
            end else begin
               cmd.step_srch = 1'b1;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_ok   = res_ok_ff;
               cmd.rsp_hit  = res_hit_ff;
               cmd.len_inc  = res_inc_ff;
               cmd.len_dec  = res_dec_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result word valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_INSERT;
         res_ok_ff    <= 1'b0;
         res_hit_ff   <= 1'b0;
         res_inc_ff   <= 1'b0;
         res_dec_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         res_ok_ff    <= res_ok_in;
         res_hit_ff   <= res_hit_in;
         res_inc_ff   <= res_inc_in;
         res_dec_ff   <= res_dec_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A result is only handed over when the output slot is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result word overwritten before it was taken");

   // A found key always comes with a successful outcome.
   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_load && cmd.rsp_hit) |-> cmd.rsp_ok)
      else $error("hit reported without success");

   // The length only moves when a result word is handed over.
   a_len_with_rsp: assert property (@(posedge clock) disable iff (reset)
      (cmd.len_inc || cmd.len_dec) |-> cmd.rsp_load)
      else $error("length changed outside result hand-over");

endmodule

### rtl/array_list_insert_delete_search.sv
// Ordered list of up to 64 signed 32-bit words held in a store with one write port
// and a registered read port. Each request word inserts at a position, searches for
// a key, deletes at a position or deletes the first word equal to a key, and yields
// one result word with ok, the found index (-1 when none) and the count after the
// request. The walk over the store moves one entry per clock cycle, bounded by
// the one read and one write port of the store. A new request is taken while the
// previous result word still waits at the output. Reset empties the list at once.
module array_list_insert_delete_search import alist_pkg::*; (
   input logic         clock,
   input logic         reset,
   alist_req_if.sink   req_if,
   alist_rsp_if.source rsp_if
);

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   alist_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_ready     (req_if.ready),
      .req_operation (req_if.operation),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .status        (status),
      .cmd           (cmd)
   );

   // Store, cursor and result word.
   alist_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_position    (req_if.position),
      .req_value       (req_if.value),
      .cmd             (cmd),
      .status          (status),
      .rsp_ok          (rsp_if.ok),
      .rsp_found_index (rsp_if.found_index),
      .rsp_count       (rsp_if.count)
   );

endmodule

### sim/tb_top.sv
module tb_top import alist_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD      = 400;
   localparam int DRAIN_CYCLES   = 300;

   localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

   // One expected result word.
   typedef struct {
      logic                    ok;
      logic signed [IDX_W-1:0] found_index;
      logic [CNT_W-1:0]        count;
   } list_result_type;

   logic clock;
   logic reset;

   alist_req_if req_bus ();
   alist_rsp_if rsp_bus ();

   array_list_insert_delete_search dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // Shadow copy of the list, updated when a request word is accepted.
   logic signed [VAL_W-1:0] list_store [CAPACITY];
   int                      list_len;

   list_result_type pending_results [$];
   int              error_count;
   int              send_idle_pct;
   int              recv_idle_pct;
   logic            hold_request;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Index of the first entry equal to the key, or -1 when none matches.
   function automatic int find_first(logic signed [VAL_W-1:0] key);
      for (int i = 0; i < list_len; i++) begin
         if (list_store[i] == key) return i;
      end
      return -1;
   endfunction

   function automatic logic remove_entry(int pos);
      if (pos >= list_len) return 1'b0;
      for (int i = pos; i + 1 < list_len; i++) list_store[i] = list_store[i + 1];
      list_len--;
      return 1'b1;
   endfunction

   // Applies one request to the shadow list and returns the result it must give.
   function automatic list_result_type apply_request(op_type op, logic [POS_W-1:0] pos,
                                                     logic signed [VAL_W-1:0] val);
      list_result_type res;
      int              hit;
      res.ok          = 1'b0;
      res.found_index = '1;
      case (op)
         OP_INSERT: begin
            if (int'(pos) <= list_len && list_len < CAPACITY) begin
               for (int i = list_len; i > int'(pos); i--) list_store[i] = list_store[i - 1];
               list_store[pos] = val;
               list_len++;
               res.ok = 1'b1;
            end
         end
         OP_SEARCH: begin
            hit = find_first(val);
            if (hit >= 0) begin
               res.ok          = 1'b1;
               res.found_index = IDX_W'(hit);
            end
         end
         OP_DELETE_POS: begin
            res.ok = remove_entry(int'(pos));
         end
         default: begin
            hit = find_first(val);
            if (hit >= 0 && remove_entry(hit)) begin
               res.ok          = 1'b1;
               res.found_index = IDX_W'(hit);
            end
         end
      endcase
      res.count = CNT_W'(list_len);
      return res;
   endfunction

   // Values lean toward the extremes and a small pool that makes duplicates.
   function automatic logic signed [VAL_W-1:0] pick_value();
      case ($urandom_range(9))
         0:       return VAL_MIN;
         1:       return VAL_MAX;
         2, 3:    return VAL_W'($urandom_range(7));
         default: return $urandom;
      endcase
   endfunction

   // Keys mostly hit a stored entry so that searches and deletes find something.
   function automatic logic signed [VAL_W-1:0] pick_key();
      if (list_len > 0 && $urandom_range(9) < 6) return list_store[$urandom_range(list_len - 1)];
      return pick_value();
   endfunction

   // Offers one request word and records its expected result when it is taken.
   task automatic send_word(op_type op, logic [POS_W-1:0] pos, logic signed [VAL_W-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.position  <= pos;
      req_bus.value     <= val;
      do @(posedge clock); while (!req_bus.ready);
      pending_results.push_back(apply_request(op, pos, val));
   endtask

   // Empty list, bad positions, extreme values, duplicates and misses.
   task automatic test_directed();
      send_word(OP_SEARCH, 7'd0, 32'sd0);
      send_word(OP_DELETE_POS, 7'd0, 32'sd0);
      send_word(OP_DELETE_VAL, 7'd0, 32'sd5);
      send_word(OP_INSERT, 7'd1, 32'sd9);
      send_word(OP_INSERT, 7'd127, 32'sd9);
      send_word(OP_INSERT, 7'd0, VAL_MIN);
      send_word(OP_INSERT, 7'd1, VAL_MAX);
      send_word(OP_INSERT, 7'd0, -32'sd1);
      send_word(OP_INSERT, 7'd3, 32'sd0);
      send_word(OP_INSERT, 7'd1, 32'sh1234_5678);
      send_word(OP_INSERT, 7'd64, 32'sd1);
      send_word(OP_SEARCH, 7'd127, VAL_MAX);
      send_word(OP_SEARCH, 7'd0, 32'sd0);
      send_word(OP_SEARCH, 7'd0, 32'sh55);
      send_word(OP_DELETE_POS, 7'd5, 32'sd0);
      send_word(OP_DELETE_POS, 7'd64, 32'sd0);
      send_word(OP_DELETE_POS, 7'd127, -32'sd1);
      send_word(OP_DELETE_VAL, 7'd127, VAL_MIN);
      send_word(OP_DELETE_POS, 7'd0, 32'sd0);
      send_word(OP_DELETE_POS, 7'd2, 32'sd0);
      send_word(OP_INSERT, 7'd2, 32'sh1234_5678);
      send_word(OP_SEARCH, 7'd0, 32'sh1234_5678);
      send_word(OP_DELETE_VAL, 7'd0, 32'sh1234_5678);
      send_word(OP_SEARCH, 7'd0, 32'sh1234_5678);
      send_word(OP_DELETE_VAL, 7'd0, VAL_MAX);
   endtask

   // Grows the list to capacity, knocks on the full list, then drains it.
   task automatic test_fill_drain();
      while (list_len < CAPACITY) begin
         if ($urandom_range(9) == 0) send_word(OP_SEARCH, POS_W'($urandom_range(127)), pick_key());
         else send_word(OP_INSERT, POS_W'($urandom_range(list_len)), pick_value());
      end
      repeat (3) send_word(OP_INSERT, POS_W'($urandom_range(list_len)), pick_value());
      send_word(OP_SEARCH, POS_W'($urandom_range(127)), pick_key());
      while (list_len > 0) begin
         case ($urandom_range(3))
            0: send_word(OP_DELETE_POS, POS_W'($urandom_range(list_len - 1)), pick_value());
            1: send_word(OP_DELETE_VAL, POS_W'($urandom_range(127)), pick_key());
            2: send_word(OP_SEARCH, POS_W'($urandom_range(127)), pick_key());
            default: send_word(OP_DELETE_POS, POS_W'($urandom_range(127)), pick_value());
         endcase
      end
   endtask

   // Mixed requests with mostly reachable positions and some wild ones.
   task automatic test_random_mix(int n);
      op_type           op;
      logic [POS_W-1:0] pos;
      repeat (n) begin
         op = op_type'($urandom_range(3));
         if ($urandom_range(4) == 0) pos = POS_W'($urandom_range(127));
         else pos = POS_W'($urandom_range(list_len));
         if (op == OP_INSERT) send_word(op, pos, pick_value());
         else send_word(op, pos, pick_key());
      end
   endtask

   // The receiver stops for a long stretch while requests keep coming.
   task automatic test_backpressure();
      hold_request = 1'b1;
      test_random_mix(24);
   endtask

   // Result checker and receiver ready generation.
   initial begin : result_checker
      int              hold_left;
      list_result_type want;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               $error("result word with nothing expected: ok=%0b found_index=%0d count=%0d",
                      rsp_bus.ok, rsp_bus.found_index, rsp_bus.count);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_bus.ok !== want.ok) begin
                  $error("ok: expected %0b, actual %0b", want.ok, rsp_bus.ok);
                  error_count++;
               end
               if (rsp_bus.found_index !== want.found_index) begin
                  $error("found_index: expected %0d, actual %0d",
                         want.found_index, rsp_bus.found_index);
                  error_count++;
               end
               if (rsp_bus.count !== want.count) begin
                  $error("count: expected %0d, actual %0d", want.count, rsp_bus.count);
                  error_count++;
               end
            end
         end
         if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog: too long without any word moving on either channel.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[array_list_insert_delete_search] ERROR");
            $finish;
         end
      end
   end

   initial begin
      list_len      = 0;
      error_count   = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = 1'b0;
      foreach (list_store[i]) list_store[i] = '0;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.operation <= OP_INSERT;
      req_bus.position  <= '0;
      req_bus.value     <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Sender mostly busy, receiver often stalling.
      send_idle_pct = 7;
      recv_idle_pct = 59;
      test_directed();
      test_fill_drain();
      test_random_mix(55);

      // Sender often idle, receiver mostly ready.
      send_idle_pct = 59;
      recv_idle_pct = 7;
      test_fill_drain();
      test_random_mix(55);

      // Full speed on both sides, apart from one long receiver hold.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_fill_drain();
      test_random_mix(55);

      // Let the last results come out, then a quiet tail.
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[array_list_insert_delete_search] OK");
      end else begin
         $display("[array_list_insert_delete_search] ERROR");
      end
      $finish;
   end

endmodule
